// ----- rtl/fsts_pkg.sv -----
// Shared widths, register indexes and word types for the floor span texture setup block.
`timescale 1ns / 1ps

package fsts_pkg;

  // Field widths
  localparam int ROW_W       = 9;
  localparam int COL_W       = 10;
  localparam int DX_W        = COL_W + 1;
  localparam int FIX_W       = 32;
  localparam int HEIGHT_W    = 31;
  localparam int SLOPE_W     = 31;
  localparam int TRIG_W      = 18;
  localparam int SHIFT_W     = 5;
  localparam int LIGHT_W     = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Divider: quotient bits resolved per stage and stage count
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = FIX_W / DIV_STEP;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_HEIGHT  = 3'd0,
    REG_EYE_X         = 3'd1,
    REG_EYE_Y         = 3'd2,
    REG_VIEW_SINE     = 3'd3,
    REG_VIEW_COSINE   = 3'd4,
    REG_CENTRE_COLUMN = 3'd5,
    REG_CENTRE_ROW    = 3'd6,
    REG_LIGHT_SHIFT   = 3'd7
  } cfg_reg_t;

  // Input word: one span
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   first_column;
    logic [COL_W-1:0]   last_column;
    logic [SLOPE_W-1:0] row_slope;
  } span_in_t;

  // Output word: texture setup for one span
  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_first;
    logic [COL_W-1:0]        out_last;
    logic signed [FIX_W-1:0] tex_u_start;
    logic signed [FIX_W-1:0] tex_v_start;
    logic signed [FIX_W-1:0] tex_u_step;
    logic signed [FIX_W-1:0] tex_v_step;
    logic [LIGHT_W-1:0]      light_index;
  } span_out_t;

endpackage

// ----- rtl/fsts_div.sv -----
// Pipelined signed-by-unsigned divider, truncating toward zero, four quotient bits per stage.
`timescale 1ns / 1ps

module fsts_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [fsts_pkg::FIX_W-1:0]           magnitude,
  input  logic [fsts_pkg::ROW_W-1:0]           divisor,
  input  logic                                 negative,
  output logic signed [fsts_pkg::FIX_W-1:0]    quotient
);
  import fsts_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] rem;
    logic [FIX_W-1:0] work;
    logic [ROW_W-1:0] dvs;
    logic             neg;
  } div_stage_t;

  div_stage_t seed;
  div_stage_t stage_next [DIV_STAGES];
  div_stage_t stage      [DIV_STAGES];

  // Restoring division: shift one dividend bit into the remainder, subtract if it fits
  function automatic div_stage_t div_step(div_stage_t s);
    logic [ROW_W:0] trial;
    div_stage_t     r;
    r = s;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial  = {r.rem, r.work[FIX_W-1]};
      r.work = {r.work[FIX_W-2:0], 1'b0};
      if (trial >= {1'b0, r.dvs}) begin
        trial     = trial - {1'b0, r.dvs};
        r.work[0] = 1'b1;
      end
      r.rem = trial[ROW_W-1:0];
    end
    return r;
  endfunction

  // Load a fresh dividend with a clear remainder
  always_comb begin
    seed.rem  = '0;
    seed.work = magnitude;
    seed.dvs  = divisor;
    seed.neg  = negative;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stage_next[s] = div_step(seed);
    end else begin : g_rest
      assign stage_next[s] = div_step(stage[s-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[s] <= stage_next[s];
      end
    end
  end

  // Apply the dividend sign to the unsigned quotient
  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= stage[DIV_STAGES-1].neg ? -$signed(stage[DIV_STAGES-1].work)
                                          : $signed(stage[DIV_STAGES-1].work);
    end
  end

endmodule

// ----- rtl/floor_span_texture_setup.sv -----
// Top level: perspective texture setup for horizontal floor and ceiling spans.
`timescale 1ns / 1ps

// Usage
//   span channel (span_valid/span_ready/span): one word per floor or ceiling span,
//   holding row, first and last column and the row's distance slope.
//   setup channel (setup_valid/setup_ready/setup): one word per span with the 16.16
//   texture start, per-pixel texture steps and a clamped light index.
//   A span on the horizon row is accepted and dropped; it yields no word.
//   Configuration goes through cfg_we/cfg_index/cfg_data, one register per cycle; the user
//   must write it only while no span is in flight, which the block itself does not enforce.
//   A span passes stage A, stage B, the two pipelined step dividers (eight stages of
//   four quotient bits, plus a sign stage), stage M and the output register.
//   Throughput is one span per cycle while the receiver does not hold setup_ready low.
//   When the receiver holds setup_ready low with a word waiting, every stage holds
//   and span_ready drops in the same cycle; nothing is lost or repeated.
//   Synchronous reset empties the pipeline and loads the default view registers.
module floor_span_texture_setup #(
  parameter int LIGHT_TABLE_SIZE = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  span_valid,
  output logic                                  span_ready,
  input  fsts_pkg::span_in_t                    span,
  output logic                                  setup_valid,
  input  logic                                  setup_ready,
  output fsts_pkg::span_out_t                   setup,
  input  logic                                  cfg_we,
  input  logic [fsts_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fsts_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import fsts_pkg::*;

  localparam int SIDE_DEPTH = DIV_STAGES + 1;
  localparam logic [FIX_W-1:0] LightLimit = FIX_W'(LIGHT_TABLE_SIZE - 1);

  // Words that ride beside the dividers
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        first;
    logic [COL_W-1:0]        last;
    logic signed [DX_W-1:0]  dx;
    logic [FIX_W-1:0]        cu;
    logic [FIX_W-1:0]        sd;
    logic [LIGHT_W-1:0]      light;
  } side_t;

  // Configuration registers
  logic [HEIGHT_W-1:0]      plane_height;
  logic [FIX_W-1:0]         eye_x;
  logic [FIX_W-1:0]         eye_y;
  logic signed [TRIG_W-1:0] view_sine;
  logic signed [TRIG_W-1:0] view_cosine;
  logic [COL_W-1:0]         centre_column;
  logic [ROW_W-1:0]         centre_row;
  logic [SHIFT_W-1:0]       light_shift;

  logic advance;

  // Stage A: captured span
  logic                   a_v;
  logic [ROW_W-1:0]       a_row;
  logic [COL_W-1:0]       a_first;
  logic [COL_W-1:0]       a_last;
  logic [SLOPE_W-1:0]     a_slope;
  logic [ROW_W-1:0]       a_dy;
  logic signed [DX_W-1:0] a_dx;
  logic [ROW_W-1:0]       dy_next;
  logic signed [DX_W-1:0] dx_next;

  // Stage B: first products
  logic                   b_v;
  logic [ROW_W-1:0]       b_row;
  logic [COL_W-1:0]       b_first;
  logic [COL_W-1:0]       b_last;
  logic [ROW_W-1:0]       b_dy;
  logic signed [DX_W-1:0] b_dx;
  logic [FIX_W-1:0]       b_dist;
  logic [FIX_W-1:0]       b_su;
  logic [FIX_W-1:0]       b_sv;
  logic [SLOPE_W+HEIGHT_W-1:0]   prod_dist;
  logic signed [TRIG_W+FIX_W-1:0] prod_su;
  logic signed [TRIG_W+FIX_W-1:0] prod_sv;

  // Divider ports
  logic [FIX_W-1:0]        mag_u;
  logic [FIX_W-1:0]        mag_v;
  logic signed [FIX_W-1:0] q_u;
  logic signed [FIX_W-1:0] q_v;

  // Side line
  side_t                          side_next;
  side_t                          side   [SIDE_DEPTH];
  logic  [SIDE_DEPTH-1:0]         side_v;
  logic signed [TRIG_W+FIX_W-1:0] prod_cu;
  logic signed [TRIG_W+FIX_W-1:0] prod_sd;
  logic [FIX_W-1:0]               light_raw;

  // Stage M: step products and bases
  logic                          m_v;
  logic [ROW_W-1:0]              m_row;
  logic [COL_W-1:0]              m_first;
  logic [COL_W-1:0]              m_last;
  logic [FIX_W-1:0]              m_uprod;
  logic [FIX_W-1:0]              m_vprod;
  logic [FIX_W-1:0]              m_ubase;
  logic [FIX_W-1:0]              m_vbase;
  logic signed [FIX_W-1:0]       m_ustep;
  logic signed [FIX_W-1:0]       m_vstep;
  logic [LIGHT_W-1:0]            m_light;
  logic signed [DX_W+FIX_W-1:0]  prod_u;
  logic signed [DX_W+FIX_W-1:0]  prod_v;

  // Hold every stage while a finished word waits
  assign advance    = !setup_valid || setup_ready;
  assign span_ready = advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height  <= '0;
      eye_x         <= '0;
      eye_y         <= '0;
      view_sine     <= '0;
      view_cosine   <= TRIG_W'(65536);
      centre_column <= COL_W'(160);
      centre_row    <= ROW_W'(100);
      light_shift   <= SHIFT_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLANE_HEIGHT:  plane_height  <= cfg_data[HEIGHT_W-1:0];
        REG_EYE_X:         eye_x         <= cfg_data[FIX_W-1:0];
        REG_EYE_Y:         eye_y         <= cfg_data[FIX_W-1:0];
        REG_VIEW_SINE:     view_sine     <= $signed(cfg_data[TRIG_W-1:0]);
        REG_VIEW_COSINE:   view_cosine   <= $signed(cfg_data[TRIG_W-1:0]);
        REG_CENTRE_COLUMN: centre_column <= cfg_data[COL_W-1:0];
        REG_CENTRE_ROW:    centre_row    <= cfg_data[ROW_W-1:0];
        REG_LIGHT_SHIFT:   light_shift   <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Row distance from horizon and column offset from centre
  always_comb begin
    dy_next = (centre_row >= span.row) ? centre_row - span.row : span.row - centre_row;
    dx_next = $signed({1'b0, span.first_column}) - $signed({1'b0, centre_column});
  end

  // Stage A: capture the span, drop horizon rows
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (advance) begin
      a_v <= span_valid && (dy_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_row   <= span.row;
      a_first <= span.first_column;
      a_last  <= span.last_column;
      a_slope <= span.row_slope;
      a_dy    <= dy_next;
      a_dx    <= dx_next;
    end
  end

  // Stage B: distance and unscaled steps
  always_comb begin
    prod_dist = (SLOPE_W+HEIGHT_W)'(a_slope) * (SLOPE_W+HEIGHT_W)'(plane_height);
    prod_su   = (TRIG_W+FIX_W)'(view_sine)
              * (TRIG_W+FIX_W)'($signed({1'b0, plane_height}));
    prod_sv   = (TRIG_W+FIX_W)'(view_cosine)
              * (TRIG_W+FIX_W)'($signed({1'b0, plane_height}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (advance) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_row   <= a_row;
      b_first <= a_first;
      b_last  <= a_last;
      b_dy    <= a_dy;
      b_dx    <= a_dx;
      b_dist  <= prod_dist[FIX_W+15:16];
      b_su    <= prod_su[FIX_W+15:16];
      b_sv    <= prod_sv[FIX_W+15:16];
    end
  end

  // Divide the steps by the row distance
  assign mag_u = b_su[FIX_W-1] ? FIX_W'(-b_su) : b_su;
  assign mag_v = b_sv[FIX_W-1] ? FIX_W'(-b_sv) : b_sv;

  fsts_div u_div_u (
    .clk       (clk),
    .en        (advance),
    .magnitude (mag_u),
    .divisor   (b_dy),
    .negative  (b_su[FIX_W-1]),
    .quotient  (q_u)
  );

  fsts_div u_div_v (
    .clk       (clk),
    .en        (advance),
    .magnitude (mag_v),
    .divisor   (b_dy),
    .negative  (b_sv[FIX_W-1]),
    .quotient  (q_v)
  );

  // Side stage C: rotated distance terms and clamped light
  always_comb begin
    prod_cu   = (TRIG_W+FIX_W)'(view_cosine) * (TRIG_W+FIX_W)'($signed(b_dist));
    prod_sd   = (TRIG_W+FIX_W)'(view_sine) * (TRIG_W+FIX_W)'($signed(b_dist));
    light_raw = b_dist >> light_shift;
    side_next.row   = b_row;
    side_next.first = b_first;
    side_next.last  = b_last;
    side_next.dx    = b_dx;
    side_next.cu    = prod_cu[FIX_W+15:16];
    side_next.sd    = prod_sd[FIX_W+15:16];
    side_next.light = (light_raw > LightLimit) ? LightLimit[LIGHT_W-1:0]
                                               : light_raw[LIGHT_W-1:0];
  end

  // Advance the side line in step with the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      side_v <= '0;
    end else if (advance) begin
      side_v <= {side_v[SIDE_DEPTH-2:0], b_v};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side[0] <= side_next;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Stage M: column offset times step, start bases
  always_comb begin
    prod_u = (DX_W+FIX_W)'(side[SIDE_DEPTH-1].dx) * (DX_W+FIX_W)'(q_u);
    prod_v = (DX_W+FIX_W)'(side[SIDE_DEPTH-1].dx) * (DX_W+FIX_W)'(q_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (advance) begin
      m_v <= side_v[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_row   <= side[SIDE_DEPTH-1].row;
      m_first <= side[SIDE_DEPTH-1].first;
      m_last  <= side[SIDE_DEPTH-1].last;
      m_uprod <= prod_u[FIX_W-1:0];
      m_vprod <= prod_v[FIX_W-1:0];
      m_ubase <= eye_x + side[SIDE_DEPTH-1].cu;
      m_vbase <= FIX_W'(0) - eye_y - side[SIDE_DEPTH-1].sd;
      m_ustep <= q_u;
      m_vstep <= q_v;
      m_light <= side[SIDE_DEPTH-1].light;
    end
  end

  // Output register: final sums
  always_ff @(posedge clk) begin
    if (rst) begin
      setup_valid <= 1'b0;
    end else if (advance) begin
      setup_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      setup.out_row     <= m_row;
      setup.out_first   <= m_first;
      setup.out_last    <= m_last;
      setup.tex_u_start <= $signed(m_ubase + m_uprod);
      setup.tex_v_start <= $signed(m_vbase + m_vprod);
      setup.tex_u_step  <= m_ustep;
      setup.tex_v_step  <= m_vstep;
      setup.light_index <= m_light;
    end
  end

endmodule

// ----- test/span_setup_checker.sv -----
// Checker for the floor span texture setup block: predicts each setup word and compares it.
`timescale 1ns / 1ps

module span_setup_checker #(
  parameter int LIGHT_TABLE_SIZE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             span_valid,
  input  logic                             span_ready,
  input  fsts_pkg::span_in_t               span,
  input  logic                             setup_valid,
  input  logic                             setup_ready,
  input  fsts_pkg::span_out_t              setup,
  input  logic                             cfg_we,
  input  logic [fsts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fsts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               spans_taken,
  output int                               horizon_spans,
  output int                               words_checked
);

  import fsts_pkg::*;

  // View registers as the block should hold them
  logic [HEIGHT_W-1:0]      height;
  logic signed [FIX_W-1:0]  eye_x;
  logic signed [FIX_W-1:0]  eye_y;
  logic signed [TRIG_W-1:0] sine;
  logic signed [TRIG_W-1:0] cosine;
  logic [COL_W-1:0]         centre_col;
  logic [ROW_W-1:0]         centre_row;
  logic [SHIFT_W-1:0]       light_shift;

  span_out_t setup_due[$];
  span_out_t want;

  // 16.16 multiply: full signed product, floor shift, keep the low 32 bits
  function automatic logic signed [FIX_W-1:0] fix_mul(longint a, longint b);
    longint p;
    p = (a * b) >>> 16;
    return p[FIX_W-1:0];
  endfunction

  // Texture start, steps and light index for one span off the horizon row
  function automatic span_out_t texture_setup(span_in_t s);
    longint dy;
    longint span_dist;
    longint u_step;
    longint v_step;
    longint dx;
    longint u0;
    longint v0;
    logic [FIX_W-1:0] dist_bits;
    logic [FIX_W-1:0] light;
    span_out_t w;
    dy = longint'(centre_row) - longint'(s.row);
    if (dy < 0) dy = -dy;
    span_dist = fix_mul(height, s.row_slope);
    u_step    = longint'(fix_mul(sine, height)) / dy;
    v_step    = longint'(fix_mul(cosine, height)) / dy;
    dx        = longint'(s.first_column) - longint'(centre_col);
    u0 = longint'(eye_x) + longint'(fix_mul(cosine, span_dist)) + dx * u_step;
    v0 = -longint'(eye_y) - longint'(fix_mul(sine, span_dist)) + dx * v_step;
    // negative or wrapped distance reads as a large unsigned value and saturates
    dist_bits = span_dist[FIX_W-1:0];
    light = dist_bits >> light_shift;
    if (light > LIGHT_TABLE_SIZE - 1) light = LIGHT_TABLE_SIZE - 1;
    w.out_row     = s.row;
    w.out_first   = s.first_column;
    w.out_last    = s.last_column;
    w.tex_u_start = u0[FIX_W-1:0];
    w.tex_v_start = v0[FIX_W-1:0];
    w.tex_u_step  = u_step[FIX_W-1:0];
    w.tex_v_step  = v_step[FIX_W-1:0];
    w.light_index = light[LIGHT_W-1:0];
    return w;
  endfunction

  task automatic report(string what, logic [FIX_W-1:0] got, logic [FIX_W-1:0] exp_val);
    $display("%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Track configuration, queue predictions, compare every setup word taken
  always @(posedge clk) begin
    if (rst) begin
      height      = '0;
      eye_x       = '0;
      eye_y       = '0;
      sine        = '0;
      cosine      = 18'sd65536;
      centre_col  = 10'd160;
      centre_row  = 9'd100;
      light_shift = 5'd20;
      setup_due.delete();
    end else begin
      if (setup_valid && setup_ready) begin
        if (setup_due.size() == 0) begin
          report("setup word with none due, row", FIX_W'(setup.out_row), '0);
        end else begin
          want = setup_due.pop_front();
          words_checked++;
          if (setup.out_row !== want.out_row)
            report("out_row", FIX_W'(setup.out_row), FIX_W'(want.out_row));
          if (setup.out_first !== want.out_first)
            report("out_first", FIX_W'(setup.out_first), FIX_W'(want.out_first));
          if (setup.out_last !== want.out_last)
            report("out_last", FIX_W'(setup.out_last), FIX_W'(want.out_last));
          if (setup.tex_u_start !== want.tex_u_start)
            report("tex_u_start", setup.tex_u_start, want.tex_u_start);
          if (setup.tex_v_start !== want.tex_v_start)
            report("tex_v_start", setup.tex_v_start, want.tex_v_start);
          if (setup.tex_u_step !== want.tex_u_step)
            report("tex_u_step", setup.tex_u_step, want.tex_u_step);
          if (setup.tex_v_step !== want.tex_v_step)
            report("tex_v_step", setup.tex_v_step, want.tex_v_step);
          if (setup.light_index !== want.light_index)
            report("light_index", FIX_W'(setup.light_index), FIX_W'(want.light_index));
        end
      end
      if (span_valid && span_ready) begin
        spans_taken++;
        // drop spans on the horizon row: no word comes out
        if (span.row == centre_row) horizon_spans++;
        else setup_due.push_back(texture_setup(span));
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PLANE_HEIGHT:  height      = cfg_data[HEIGHT_W-1:0];
          REG_EYE_X:         eye_x       = cfg_data;
          REG_EYE_Y:         eye_y       = cfg_data;
          REG_VIEW_SINE:     sine        = cfg_data[TRIG_W-1:0];
          REG_VIEW_COSINE:   cosine      = cfg_data[TRIG_W-1:0];
          REG_CENTRE_COLUMN: centre_col  = cfg_data[COL_W-1:0];
          REG_CENTRE_ROW:    centre_row  = cfg_data[ROW_W-1:0];
          REG_LIGHT_SHIFT:   light_shift = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = setup_due.size();
  end

endmodule

// ----- test/floor_span_texture_setup_tb.sv -----
// Testbench top for the floor span texture setup block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module floor_span_texture_setup_tb;

  import fsts_pkg::*;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PATTERN
  } rx_mode_t;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic [FIX_W-1:0]    eye_x;
    logic [FIX_W-1:0]    eye_y;
    logic [TRIG_W-1:0]   sine;
    logic [TRIG_W-1:0]   cosine;
    logic [COL_W-1:0]    centre_col;
    logic [ROW_W-1:0]    centre_row;
    logic [SHIFT_W-1:0]  shift;
  } view_t;

  logic                   clk;
  logic                   rst;
  logic                   span_valid;
  logic                   span_ready;
  span_in_t               span;
  logic                   setup_valid;
  logic                   setup_ready;
  span_out_t              setup;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int spans_taken;
  int horizon_spans;
  int words_checked;

  rx_mode_t       rx_mode = RX_ALWAYS;
  logic           hold_req = 1'b0;
  logic [ROW_W-1:0] horizon_row = 9'd100;
  int             view_count = 0;

  floor_span_texture_setup u_top (
    .clk         (clk),
    .rst         (rst),
    .span_valid  (span_valid),
    .span_ready  (span_ready),
    .span        (span),
    .setup_valid (setup_valid),
    .setup_ready (setup_ready),
    .setup       (setup),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  span_setup_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .span_valid    (span_valid),
    .span_ready    (span_ready),
    .span          (span),
    .setup_valid   (setup_valid),
    .setup_ready   (setup_ready),
    .setup         (setup),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .spans_taken   (spans_taken),
    .horizon_spans (horizon_spans),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: stall on the current pattern, or hold off for a long stretch on request
  initial begin : receiver
    int tick;
    tick = 0;
    setup_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        setup_ready <= 1'b0;
        repeat (100) @(negedge clk);
      end else begin
        tick++;
        case (rx_mode)
          RX_ALWAYS: setup_ready <= 1'b1;
          RX_COIN:   setup_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: setup_ready <= ($urandom_range(0, 3) != 0);
          default:   setup_ready <= (tick % 9) < 5;
        endcase
      end
    end
  end

  function automatic span_in_t make_span(int r, int first, int last, int slope);
    span_in_t s;
    s.row          = r[ROW_W-1:0];
    s.first_column = first[COL_W-1:0];
    s.last_column  = last[COL_W-1:0];
    s.row_slope    = slope[SLOPE_W-1:0];
    return s;
  endfunction

  // Mostly ordered spans off the horizon; some swapped, some on the horizon row
  function automatic span_in_t random_span();
    span_in_t s;
    logic [COL_W-1:0] a;
    logic [COL_W-1:0] b;
    a = COL_W'($urandom_range(0, 1023));
    b = COL_W'($urandom_range(0, 1023));
    s.row = ($urandom_range(0, 15) == 0) ? horizon_row : 9'($urandom_range(0, 511));
    if ($urandom_range(0, 9) != 0) begin
      s.first_column = (a < b) ? a : b;
      s.last_column  = (a < b) ? b : a;
    end else begin
      s.first_column = a;
      s.last_column  = b;
    end
    case ($urandom_range(0, 7))
      0:       s.row_slope = SLOPE_W'($urandom());
      1:       s.row_slope = '0;
      2:       s.row_slope = '1;
      3:       s.row_slope = SLOPE_W'($urandom_range(0, 32'h00FF_FFFF));
      default: s.row_slope = SLOPE_W'($urandom_range(0, 32'h0003_FFFF));
    endcase
    return s;
  endfunction

  function automatic view_t random_view();
    view_t v;
    if ($urandom_range(0, 2) == 0) v.height = HEIGHT_W'($urandom());
    else v.height = HEIGHT_W'(($urandom_range(1, 512) << 16) | $urandom_range(0, 65535));
    v.eye_x      = $urandom();
    v.eye_y      = $urandom();
    v.sine       = TRIG_W'($urandom_range(0, 131072) - 65536);
    v.cosine     = TRIG_W'($urandom_range(0, 131072) - 65536);
    v.centre_col = COL_W'($urandom_range(0, 1023));
    v.centre_row = ROW_W'($urandom_range(0, 511));
    v.shift      = SHIFT_W'($urandom_range(0, 31));
    return v;
  endfunction

  // Corner settings: largest and smallest values of the registers, sine and cosine at 0 or plus or minus 1.0
  function automatic view_t corner_view(int k);
    view_t v;
    v.height     = (k == 1) ? '0 : '1;
    v.eye_x      = (k == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    v.eye_y      = (k == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v.sine       = (k == 0) ? 18'h10000 : 18'h30000;
    v.cosine     = (k == 0) ? 18'h30000 : ((k == 1) ? 18'h10000 : 18'h00000);
    v.centre_col = (k == 0) ? 10'd1023 : 10'd0;
    v.centre_row = (k == 1) ? 9'd0 : 9'd511;
    v.shift      = (k == 0) ? 5'd31 : 5'd0;
    return v;
  endfunction

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_view(view_t v);
    put_reg(REG_PLANE_HEIGHT, {1'b0, v.height});
    put_reg(REG_EYE_X, v.eye_x);
    put_reg(REG_EYE_Y, v.eye_y);
    put_reg(REG_VIEW_SINE, {{(CFG_DATA_W - TRIG_W){v.sine[TRIG_W-1]}}, v.sine});
    put_reg(REG_VIEW_COSINE, {{(CFG_DATA_W - TRIG_W){v.cosine[TRIG_W-1]}}, v.cosine});
    put_reg(REG_CENTRE_COLUMN, CFG_DATA_W'(v.centre_col));
    put_reg(REG_CENTRE_ROW, CFG_DATA_W'(v.centre_row));
    put_reg(REG_LIGHT_SHIFT, CFG_DATA_W'(v.shift));
    cfg_we <= 1'b0;
    horizon_row = v.centre_row;
    view_count++;
  endtask

  // Offer one word and hold it until taken
  task automatic put_span(span_in_t s);
    span_valid <= 1'b1;
    span       <= s;
    do @(posedge clk); while (!span_ready);
    @(negedge clk);
  endtask

  task automatic idle(int n);
    span_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait for every due word, then let dropped horizon spans leave the pipeline
  task automatic drain();
    span_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic send_bursts(int count, bit gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        put_span(random_span());
        sent++;
      end
      if (gaps && $urandom_range(0, 3) != 0) idle($urandom_range(1, 10));
    end
  endtask

  initial begin : stimulus
    view_t v;
    rst        = 1'b1;
    span_valid = 1'b0;
    span       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Registers at their reset values
    put_span(make_span(100, 0, 319, 32'h0001_0000));
    put_span(make_span(0, 1023, 0, 32'h7FFF_FFFF));
    put_span(make_span(511, 0, 1023, 0));
    drain();

    // Typical view, then the field extremes and special spans
    v.height     = 31'h0020_0000;
    v.eye_x      = 32'h0123_4567;
    v.eye_y      = 32'hFEDC_BA98;
    v.sine       = 18'd46341;
    v.cosine     = -18'sd46341;
    v.centre_col = 10'd160;
    v.centre_row = 9'd100;
    v.shift      = 5'd16;
    load_view(v);
    put_span(make_span(100, 10, 200, 32'h0001_0000));
    put_span(make_span(99, 160, 160, 32'h0001_0000));
    put_span(make_span(101, 0, 1023, 32'h0000_8000));
    put_span(make_span(0, 0, 1023, 1));
    put_span(make_span(511, 1023, 1023, 32'h0002_0000));
    put_span(make_span(50, 1023, 0, 32'h0001_8000));
    put_span(make_span(150, 0, 0, 0));
    put_span(make_span(20, 300, 310, 32'h7FFF_FFFF));
    put_span(make_span(180, 5, 900, 32'h0003_F800));
    put_span(make_span(180, 5, 900, 32'h0003_F7FF));
    put_span(make_span(300, 512, 511, 32'h4000_0000));
    put_span(make_span(100, 1023, 0, 32'h7FFF_FFFF));
    put_span(make_span(1, 1, 2, 32'h0000_FFFF));
    put_span(make_span(255, 640, 700, 32'h1234_5678));
    drain();

    // Random phases, each under its own view setting and receiver pattern
    for (int p = 0; p < 12; p++) begin
      if (p < 3) v = corner_view(p);
      else v = random_view();
      load_view(v);
      rx_mode = (p == 0) ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 3));
      if (p == 4) begin
        // hold off the receiver while spans keep coming so the pipeline backs up
        hold_req = 1'b1;
        repeat (60) put_span(random_span());
      end
      send_bursts(105, p != 1);
      drain();
    end

    $display("Checked %0d setup words from %0d spans (%0d on the horizon row), %0d mismatches,",
             words_checked, spans_taken, horizon_spans, mismatches);
    $display("over %0d view settings with bursty input and receiver stalls.", view_count);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
